// ===== hdl/tchf_pkg.sv =====
// Shared constants, state type and arctangent table for the heading fusion block.
package tchf_pkg;

    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_FRAC_BITS = 7;
    localparam int TABLE_LEN       = 24;
    localparam int CSTEPS          = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int OUT_SHIFT       = 16 - ANGLE_FRAC_BITS;
    localparam int FULL_UNITS      = 360 << ANGLE_FRAC_BITS;
    localparam int HALF_UNITS      = 180 << ANGLE_FRAC_BITS;
    localparam int UW              = $clog2(FULL_UNITS) + 3;

    localparam int CW  = 36;
    localparam int ZW  = 26;
    localparam int PW  = 68;
    localparam int MAW = 36;
    localparam int MBW = 32;
    localparam int SHW = 5;
    localparam int CNW = 6;

    localparam int     HALF_TURN    = 180 * 65536;
    localparam int     QUARTER_TURN = 90 * 65536;
    localparam longint KINV_Q30     = 652032875;
    localparam longint GYRO_DEN     = 131000000;

    localparam int QW  = ANGLE_FRAC_BITS + 6;
    localparam int DVW = ANGLE_FRAC_BITS + 33;

    localparam int BW          = 17;
    localparam int BLEND_RESET = 64225;
    localparam int ALPHA_ONE   = 65536;

    localparam int MUL_LAST  = MBW + 1;
    localparam int COR_LAST  = CSTEPS + 1;
    localparam int SQRT_LAST = 17;
    localparam int DIV_LAST  = QW + 1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQY,
        ST_SQZ,
        ST_SQRT,
        ST_ROLL,
        ST_PITCH,
        ST_SCR,
        ST_SCP,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_M5,
        ST_M6,
        ST_HEAD,
        ST_GMUL,
        ST_GDIV,
        ST_BLA,
        ST_BLB,
        ST_DONE
    } st_t;

    // atan(2^-i) in degrees * 2^16
    function automatic logic signed [ZW-1:0] atan_at(input logic [SHW-1:0] i);
        logic signed [ZW-1:0] v;
        unique case (i)
            5'd0:    v = ZW'(2949120);
            5'd1:    v = ZW'(1740967);
            5'd2:    v = ZW'(919879);
            5'd3:    v = ZW'(466945);
            5'd4:    v = ZW'(234379);
            5'd5:    v = ZW'(117304);
            5'd6:    v = ZW'(58666);
            5'd7:    v = ZW'(29335);
            5'd8:    v = ZW'(14668);
            5'd9:    v = ZW'(7334);
            5'd10:   v = ZW'(3667);
            5'd11:   v = ZW'(1833);
            5'd12:   v = ZW'(917);
            5'd13:   v = ZW'(458);
            5'd14:   v = ZW'(229);
            5'd15:   v = ZW'(115);
            5'd16:   v = ZW'(57);
            5'd17:   v = ZW'(29);
            5'd18:   v = ZW'(14);
            5'd19:   v = ZW'(7);
            5'd20:   v = ZW'(4);
            5'd21:   v = ZW'(2);
            5'd22:   v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/tilt_compensated_heading_fusion_top.sv =====
// Tilt-compensated compass heading fused with integrated gyro yaw.
//
// Input channel s_*: one sensor sample set per transaction. Output channel m_*:
// fused heading and compass heading, one transaction per input transaction.
// Angles are in 1/128 degree, range [0,360).
// One sample is processed at a time. s_ready is high only while the datapath
// is idle; a finished result sits in the output register, so a new sample can
// be taken while m_valid waits for m_ready.
// With mag_ready set, a sample passes through one shared bit-serial multiplier
// (11 products), one shared CORDIC stage doing one micro-rotation per cycle
// (5 passes), a 16-step square root and a 13-step restoring divider for the
// gyro increment; without it only the gyro product, the divider and the two
// blend products run. s_ready returns in the same cycle that m_valid rises.
// If m_ready stays low the block holds in its final state until the previous
// result is taken, then registers the new one and accepts the next sample.
// Reset (aresetn low, synchronous) clears the yaw estimate to 0, restores
// blend_weight to 64225 and drops m_valid. cfg_wr_en writes cfg_wr_data
// into blend_weight; write it only while idle.
module tilt_compensated_heading_fusion_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [tchf_pkg::BW-1:0]     cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [15:0]          s_accel_x,
    input  logic signed [15:0]          s_accel_y,
    input  logic signed [15:0]          s_accel_z,
    input  logic signed [15:0]          s_gyro_z,
    input  logic signed [15:0]          s_mag_x,
    input  logic signed [15:0]          s_mag_y,
    input  logic signed [15:0]          s_mag_z,
    input  logic                        s_mag_ready,
    input  logic [15:0]                 s_elapsed_us,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [15:0]                 m_heading,
    output logic [15:0]                 m_compass_heading
);
    import tchf_pkg::*;

    function automatic logic signed [UW-1:0] to_units(input logic signed [ZW-1:0] z);
        logic signed [ZW:0]   s;
        logic signed [UW-1:0] v;
        s = (ZW+1)'(z) + (ZW+1)'(1 << (OUT_SHIFT - 1));
        s = s >>> OUT_SHIFT;
        v = s[UW-1:0];
        if (v < 0) v = v + UW'(FULL_UNITS);
        if (v >= UW'(FULL_UNITS)) v = v - UW'(FULL_UNITS);
        return v;
    endfunction

    st_t state_reg, state_next;
    logic [CNW-1:0] cnt_reg;
    logic [CNW-1:0] lim;
    logic           last;

    logic [BW-1:0]        blend_reg;
    logic signed [UW-1:0] yaw_reg;
    logic                 m_valid_reg;
    logic [15:0]          m_heading_reg, m_compass_reg;

    logic signed [15:0] ax_reg, ay_reg, az_reg, gz_reg, mx_reg, my_reg, mz_reg;
    logic [15:0]        us_reg;

    logic signed [UW-1:0] mag_reg, gyro_reg;
    logic [15:0]          comp_reg;

    logic signed [ZW-1:0]  roll_reg, pitch_reg;
    logic signed [MBW-1:0] sin_r_reg, cos_r_reg, sin_p_reg, cos_p_reg;
    logic signed [CW-1:0]  mxc_reg, t_reg, myc_reg;

    // shared serial multiplier
    logic signed [PW-1:0]  ma_reg, p_reg;
    logic [MBW-1:0]        mb_reg;
    logic signed [MAW-1:0] mul_a;
    logic [MBW-1:0]        mul_b;
    logic                  mul_clr, mul_en;

    // shared CORDIC stage
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic signed [ZW-1:0] cz_reg;
    logic                 cneg_reg;
    logic                 cor_en, cor_rot;
    logic signed [CW-1:0] vx, vy, cx0, cy0, xs, ys;
    logic signed [ZW-1:0] rth, cz0, at;
    logic                 cn0, up;
    logic [SHW-1:0]       sh;

    // square root
    logic [31:0] sq_v_reg, sq_r_reg, sq_bit_reg;
    logic [32:0] sq_try;
    logic        sq_en;

    // gyro increment divider
    logic [DVW-1:0]       dv_rem_reg, dv_div_reg;
    logic [QW-1:0]        dv_q_reg;
    logic                 dv_neg_reg, dv_en;
    logic signed [PW-1:0] num, nabs;

    logic signed [PW-1:0] p_sh16, p_sh30, yfull;
    logic signed [UW-1:0] q_s, gyro_c, mag_c, yaw_f;
    logic signed [UW:0]   dgm;
    logic [BW-1:0]        alpha;

    assign alpha = (blend_reg > BW'(ALPHA_ONE)) ? BW'(ALPHA_ONE) : blend_reg;
    assign last  = (cnt_reg == lim);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_valid) state_next = s_mag_ready ? ST_SQY : ST_GMUL;
            ST_SQY:   if (last) state_next = ST_SQZ;
            ST_SQZ:   if (last) state_next = ST_SQRT;
            ST_SQRT:  if (last) state_next = ST_ROLL;
            ST_ROLL:  if (last) state_next = ST_PITCH;
            ST_PITCH: if (last) state_next = ST_SCR;
            ST_SCR:   if (last) state_next = ST_SCP;
            ST_SCP:   if (last) state_next = ST_M1;
            ST_M1:    if (last) state_next = ST_M2;
            ST_M2:    if (last) state_next = ST_M3;
            ST_M3:    if (last) state_next = ST_M4;
            ST_M4:    if (last) state_next = ST_M5;
            ST_M5:    if (last) state_next = ST_M6;
            ST_M6:    if (last) state_next = ST_HEAD;
            ST_HEAD:  if (last) state_next = ST_GMUL;
            ST_GMUL:  if (last) state_next = ST_GDIV;
            ST_GDIV:  if (last) state_next = ST_BLA;
            ST_BLA:   if (last) state_next = ST_BLB;
            ST_BLB:   if (last) state_next = ST_DONE;
            ST_DONE:  if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // unit controls and operand selection
    always_comb begin
        s_ready = 1'b0;
        lim     = '0;
        mul_en  = 1'b0;
        mul_clr = 1'b1;
        mul_a   = '0;
        mul_b   = '0;
        cor_en  = 1'b0;
        cor_rot = 1'b0;
        vx      = '0;
        vy      = '0;
        rth     = '0;
        sq_en   = 1'b0;
        dv_en   = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_SQY: begin
                mul_en = 1'b1; lim = CNW'(MUL_LAST);
                mul_a = MAW'(ay_reg); mul_b = MBW'(ay_reg);
            end
            ST_SQZ: begin
                mul_en = 1'b1; lim = CNW'(MUL_LAST); mul_clr = 1'b0;
                mul_a = MAW'(az_reg); mul_b = MBW'(az_reg);
            end
            ST_SQRT: begin
                sq_en = 1'b1; lim = CNW'(SQRT_LAST);
            end
            ST_ROLL: begin
                cor_en = 1'b1; lim = CNW'(COR_LAST);
                vy = CW'(ay_reg) <<< 14;
                vx = CW'(az_reg) <<< 14;
            end
            ST_PITCH: begin
                cor_en = 1'b1; lim = CNW'(COR_LAST);
                vy = -(CW'(ax_reg) <<< 14);
                vx = signed'(CW'(sq_r_reg[16:0])) <<< 14;
            end
            ST_SCR: begin
                cor_en = 1'b1; cor_rot = 1'b1; lim = CNW'(COR_LAST); rth = roll_reg;
            end
            ST_SCP: begin
                cor_en = 1'b1; cor_rot = 1'b1; lim = CNW'(COR_LAST); rth = pitch_reg;
            end
            ST_M1: begin
                mul_en = 1'b1; lim = CNW'(MUL_LAST);
                mul_a = MAW'(mx_reg); mul_b = cos_p_reg;
            end
            ST_M2: begin
                mul_en = 1'b1; lim = CNW'(MUL_LAST); mul_clr = 1'b0;
                mul_a = MAW'(mz_reg); mul_b = sin_p_reg;
            end
            ST_M3: begin
                mul_en = 1'b1; lim = CNW'(MUL_LAST);
                mul_a = MAW'(mx_reg); mul_b = sin_p_reg;
            end
            ST_M4: begin
                mul_en = 1'b1; lim = CNW'(MUL_LAST); mul_clr = 1'b0;
                mul_a = -MAW'(mz_reg); mul_b = cos_p_reg;
            end
            ST_M5: begin
                mul_en = 1'b1; lim = CNW'(MUL_LAST);
                mul_a = MAW'(my_reg); mul_b = cos_r_reg;
            end
            ST_M6: begin
                mul_en = 1'b1; lim = CNW'(MUL_LAST);
                mul_a = MAW'(t_reg); mul_b = sin_r_reg;
            end
            ST_HEAD: begin
                cor_en = 1'b1; lim = CNW'(COR_LAST);
                vy = -myc_reg;
                vx = mxc_reg;
            end
            ST_GMUL: begin
                mul_en = 1'b1; lim = CNW'(MUL_LAST);
                mul_a = MAW'(gz_reg); mul_b = MBW'(us_reg);
            end
            ST_GDIV: begin
                dv_en = 1'b1; lim = CNW'(DIV_LAST);
            end
            ST_BLA: begin
                mul_en = 1'b1; lim = CNW'(MUL_LAST);
                mul_a = MAW'(gyro_reg); mul_b = MBW'(alpha);
            end
            ST_BLB: begin
                mul_en = 1'b1; lim = CNW'(MUL_LAST); mul_clr = 1'b0;
                mul_a = MAW'(mag_reg); mul_b = MBW'(ALPHA_ONE) - MBW'(alpha);
            end
            ST_DONE: lim = '0;
            default: lim = '0;
        endcase
    end

    // CORDIC setup: quadrant fold for rotation, half-plane flip for vectoring
    always_comb begin
        cx0 = vx;
        cy0 = vy;
        cz0 = '0;
        cn0 = 1'b0;
        if (cor_rot) begin
            cx0 = CW'(KINV_Q30);
            cy0 = '0;
            cz0 = rth;
            if (rth > ZW'(QUARTER_TURN)) begin
                cz0 = rth - ZW'(HALF_TURN);
                cn0 = 1'b1;
            end else if (rth < -ZW'(QUARTER_TURN)) begin
                cz0 = rth + ZW'(HALF_TURN);
                cn0 = 1'b1;
            end
        end else if (vx < 0) begin
            cz0 = (vy >= 0) ? ZW'(HALF_TURN) : -ZW'(HALF_TURN);
            cx0 = -vx;
            cy0 = -vy;
        end
    end

    always_comb begin
        sh = SHW'(cnt_reg - 1'b1);
        xs = cx_reg >>> sh;
        ys = cy_reg >>> sh;
        at = atan_at(sh);
        up = cor_rot ? (cz_reg >= 0) : (cy_reg <= 0);
    end

    always_comb begin
        sq_try = {1'b0, sq_r_reg} + {1'b0, sq_bit_reg};
        num    = p_reg <<< ANGLE_FRAC_BITS;
        nabs   = (num < 0) ? -num : num;
        p_sh16 = p_reg >>> 16;
        p_sh30 = p_reg >>> 30;
        q_s    = signed'(UW'(dv_q_reg));
        gyro_c = dv_neg_reg ? (yaw_reg - q_s) : (yaw_reg + q_s);
        dgm    = (UW+1)'(gyro_c) - (UW+1)'(mag_reg);
        mag_c  = mag_reg;
        if (dgm > (UW+1)'(HALF_UNITS)) begin
            mag_c = mag_reg + UW'(FULL_UNITS);
        end else if (dgm < -(UW+1)'(HALF_UNITS)) begin
            mag_c = mag_reg - UW'(FULL_UNITS);
        end
        yfull = (p_reg + PW'(32768)) >>> 16;
        yaw_f = yfull[UW-1:0];
        if (yaw_f >= UW'(FULL_UNITS)) yaw_f = yaw_f - UW'(FULL_UNITS);
        if (yaw_f < 0) yaw_f = yaw_f + UW'(FULL_UNITS);
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            blend_reg   <= BW'(BLEND_RESET);
            yaw_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE || state_reg == ST_DONE || last) begin
                cnt_reg <= '0;
            end else begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cfg_wr_en) blend_reg <= cfg_wr_data;
            if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
                yaw_reg     <= yaw_f;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            ax_reg <= s_accel_x;
            ay_reg <= s_accel_y;
            az_reg <= s_accel_z;
            gz_reg <= s_gyro_z;
            mx_reg <= s_mag_x;
            my_reg <= s_mag_y;
            mz_reg <= s_mag_z;
            us_reg <= s_elapsed_us;
            if (!s_mag_ready) mag_reg <= yaw_reg;
        end

        if (mul_en) begin
            if (cnt_reg == '0) begin
                ma_reg <= PW'(mul_a);
                mb_reg <= mul_b;
                if (mul_clr) p_reg <= '0;
            end else if (cnt_reg <= CNW'(MBW)) begin
                if (mb_reg[0]) begin
                    p_reg <= (cnt_reg == CNW'(MBW)) ? (p_reg - ma_reg) : (p_reg + ma_reg);
                end
                ma_reg <= ma_reg <<< 1;
                mb_reg <= mb_reg >> 1;
            end
        end

        if (cor_en) begin
            if (cnt_reg == '0) begin
                cx_reg   <= cx0;
                cy_reg   <= cy0;
                cz_reg   <= cz0;
                cneg_reg <= cn0;
            end else if (cnt_reg <= CNW'(CSTEPS)) begin
                if (up) begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - at;
                end else begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + at;
                end
            end
        end

        if (sq_en) begin
            if (cnt_reg == '0) begin
                sq_v_reg   <= p_reg[31:0];
                sq_r_reg   <= '0;
                sq_bit_reg <= 32'h4000_0000;
            end else if (cnt_reg <= CNW'(SQRT_LAST - 1)) begin
                if ({1'b0, sq_v_reg} >= sq_try) begin
                    sq_v_reg <= sq_v_reg - sq_try[31:0];
                    sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_r_reg <= sq_r_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
            end
        end

        if (dv_en) begin
            if (cnt_reg == '0) begin
                dv_rem_reg <= nabs[DVW-1:0] + DVW'(GYRO_DEN / 2);
                dv_div_reg <= DVW'(GYRO_DEN) << (QW - 1);
                dv_q_reg   <= '0;
                dv_neg_reg <= (p_reg < 0);
            end else if (cnt_reg <= CNW'(QW)) begin
                if (dv_rem_reg >= dv_div_reg) begin
                    dv_rem_reg <= dv_rem_reg - dv_div_reg;
                    dv_q_reg   <= {dv_q_reg[QW-2:0], 1'b1};
                end else begin
                    dv_q_reg   <= {dv_q_reg[QW-2:0], 1'b0};
                end
                dv_div_reg <= dv_div_reg >> 1;
            end
        end

        if (last) begin
            unique case (state_reg)
                ST_ROLL:  roll_reg  <= cz_reg;
                ST_PITCH: pitch_reg <= cz_reg;
                ST_SCR: begin
                    sin_r_reg <= MBW'(cneg_reg ? -cy_reg : cy_reg);
                    cos_r_reg <= MBW'(cneg_reg ? -cx_reg : cx_reg);
                end
                ST_SCP: begin
                    sin_p_reg <= MBW'(cneg_reg ? -cy_reg : cy_reg);
                    cos_p_reg <= MBW'(cneg_reg ? -cx_reg : cx_reg);
                end
                ST_M2:   mxc_reg <= p_sh16[CW-1:0];
                ST_M4:   t_reg   <= p_sh16[CW-1:0];
                ST_M5:   myc_reg <= p_sh16[CW-1:0];
                ST_M6:   myc_reg <= myc_reg + signed'(p_sh30[CW-1:0]);
                ST_HEAD: mag_reg <= to_units(cz_reg);
                ST_GDIV: begin
                    comp_reg <= mag_reg[15:0];
                    gyro_reg <= gyro_c;
                    mag_reg  <= mag_c;
                end
                default: ;
            endcase
        end

        if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
            m_heading_reg <= yaw_f[15:0];
            m_compass_reg <= comp_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_heading         = m_heading_reg;
    assign m_compass_heading = m_compass_reg;

    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_heading_reg < 16'(FULL_UNITS)) && (m_compass_reg < 16'(FULL_UNITS)))
        else $error("result angle out of range");

    a_idle_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (cnt_reg == '0))
        else $error("step counter running while idle");

    a_rise_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result posted outside final state");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != ST_IDLE))
        else $error("accepted transaction not started");

endmodule

// ===== tb/sv/tb_tilt_compensated_heading_fusion_top.sv =====
// Self-checking testbench for the tilt-compensated heading fusion block.
module tb_tilt_compensated_heading_fusion_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tchf_pkg::*;

    typedef struct {
        logic signed [15:0] ax, ay, az, gz, mx, my, mz;
        logic               rdy;
        logic [15:0]        us;
    } sample_t;

    typedef struct {
        logic [15:0] heading;
        logic [15:0] compass;
    } heading_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_wr_en = 0;
    logic [BW-1:0] cfg_wr_data = '0;
    logic s_valid = 0;
    logic s_ready;
    logic signed [15:0] s_accel_x = 0, s_accel_y = 0, s_accel_z = 0, s_gyro_z = 0;
    logic signed [15:0] s_mag_x = 0, s_mag_y = 0, s_mag_z = 0;
    logic s_mag_ready = 0;
    logic [15:0] s_elapsed_us = 0;
    logic m_valid;
    logic m_ready = 0;
    logic [15:0] m_heading, m_compass_heading;

    tilt_compensated_heading_fusion_top u_top (.*);

    initial forever #5 aclk = ~aclk;

    sample_t  pending_samples[$];
    heading_t expected_headings[$];
    int       errors = 0;
    longint   cycles = 0;
    bit       sender_hold = 0;

    // predictor state
    longint yaw_est = 0;
    longint gyro_weight = BLEND_RESET;

    function automatic longint sra(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint atan_deg(int i);
        longint tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
        return tab[i];
    endfunction

    function automatic longint isqrt(longint v);
        longint r = 0;
        longint b = 64'sd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z = 0;
        longint xn;
        if (x < 0) begin
            z = (y >= 0) ? HALF_TURN : -HALF_TURN;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CSTEPS; i++) begin
            if (y > 0) begin
                xn = x + sra(y, i); y = y - sra(x, i); z += atan_deg(i);
            end else begin
                xn = x - sra(y, i); y = y + sra(x, i); z -= atan_deg(i);
            end
            x = xn;
        end
        return z;
    endfunction

    task automatic rotate_unit(input longint th, output longint s, output longint c);
        bit neg = 0;
        longint x = KINV_Q30;
        longint y = 0;
        longint xn;
        if (th > QUARTER_TURN) begin
            th -= HALF_TURN; neg = 1;
        end else if (th < -QUARTER_TURN) begin
            th += HALF_TURN; neg = 1;
        end
        for (int i = 0; i < CSTEPS; i++) begin
            if (th >= 0) begin
                xn = x - sra(y, i); y = y + sra(x, i); th -= atan_deg(i);
            end else begin
                xn = x + sra(y, i); y = y - sra(x, i); th += atan_deg(i);
            end
            x = xn;
        end
        s = neg ? -y : y;
        c = neg ? -x : x;
    endtask

    function automatic longint angle_units(longint z);
        longint v = sra(z + (64'sd1 << (OUT_SHIFT - 1)), OUT_SHIFT);
        if (v < 0) v += FULL_UNITS;
        if (v >= FULL_UNITS) v -= FULL_UNITS;
        return v;
    endfunction

    task automatic predict_heading(input sample_t smp);
        longint ax, ay, az, gz, mx, my, mz, mag, gyro, num, q, alpha, yaw;
        longint roll, r, pitch, sr, cr, sp, cp, mxc, t, myc;
        heading_t e;
        ax = smp.ax; ay = smp.ay; az = smp.az; gz = smp.gz;
        mx = smp.mx; my = smp.my; mz = smp.mz;
        if (smp.rdy) begin
            roll = vector_angle(ay * 16384, az * 16384);
            r = isqrt(ay * ay + az * az);
            pitch = vector_angle(-ax * 16384, r * 16384);
            rotate_unit(roll, sr, cr);
            rotate_unit(pitch, sp, cp);
            mxc = sra(mx * cp + mz * sp, 16);
            t = sra(mx * sp - mz * cp, 16);
            myc = sra(my * cr, 16) + sra(sr * t, 30);
            mag = angle_units(vector_angle(-myc, mxc));
        end else begin
            mag = yaw_est;
        end
        num = gz * longint'(smp.us) * (64'sd1 << ANGLE_FRAC_BITS);
        q = ((num < 0 ? -num : num) + GYRO_DEN / 2) / GYRO_DEN;
        gyro = yaw_est + (num < 0 ? -q : q);
        e.compass = mag[15:0];
        if (gyro - mag > HALF_UNITS) mag += FULL_UNITS;
        else if (gyro - mag < -HALF_UNITS) mag -= FULL_UNITS;
        alpha = gyro_weight > ALPHA_ONE ? ALPHA_ONE : gyro_weight;
        yaw = sra(alpha * gyro + (ALPHA_ONE - alpha) * mag + 32768, 16);
        if (yaw >= FULL_UNITS) yaw -= FULL_UNITS;
        if (yaw < 0) yaw += FULL_UNITS;
        yaw_est = yaw;
        e.heading = yaw[15:0];
        expected_headings.push_back(e);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // driver
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_heading(pending_samples.pop_front());
            end
            if (!(s_valid && !s_ready)) begin
                if (gap_left > 0 || sender_hold || pending_samples.size() == 0
                    || (s_valid && s_ready && burst_left == 0)) begin
                    s_valid <= 0;
                    if (gap_left > 0) gap_left <= gap_left - 1;
                    else if (burst_left == 0 && !sender_hold) begin
                        burst_left <= $urandom_range(1, 8);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 600);
                    end
                end else begin
                    s_valid <= 1;
                    s_accel_x <= pending_samples[0].ax;
                    s_accel_y <= pending_samples[0].ay;
                    s_accel_z <= pending_samples[0].az;
                    s_gyro_z <= pending_samples[0].gz;
                    s_mag_x <= pending_samples[0].mx;
                    s_mag_y <= pending_samples[0].my;
                    s_mag_z <= pending_samples[0].mz;
                    s_mag_ready <= pending_samples[0].rdy;
                    s_elapsed_us <= pending_samples[0].us;
                    if (burst_left > 0) burst_left <= burst_left - 1;
                end
            end
        end
    end

    // monitor and receiver stall pattern
    int stall_phase = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_headings.size() == 0) begin
                    report_mismatch("unexpected transaction", m_heading, 0);
                end else begin
                    heading_t e;
                    e = expected_headings.pop_front();
                    if (m_heading !== e.heading)
                        report_mismatch("heading", m_heading, e.heading);
                    if (m_compass_heading !== e.compass)
                        report_mismatch("compass_heading", m_compass_heading, e.compass);
                end
            end
            stall_phase <= stall_phase + 1;
            case (stall_phase[9:8])
                2'd0: m_ready <= 1;
                2'd1: m_ready <= ($urandom_range(0, 3) != 0);
                2'd2: m_ready <= (stall_phase[5:0] < 50) ? 0 : 1;
                default: m_ready <= ($urandom_range(0, 1000) < 2) ? 0 : ~m_ready | 1'b1;
            endcase
        end
    end

    always @(posedge aclk) begin
        if (cycles > 4000000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic sample_t rand_sample();
        sample_t s;
        int mode = $urandom_range(0, 9);
        s.ax = 16'($urandom); s.ay = 16'($urandom); s.az = 16'($urandom);
        s.mx = 16'($urandom); s.my = 16'($urandom); s.mz = 16'($urandom);
        s.gz = 16'($urandom);
        if (mode < 6) begin
            s.ax = 16'($signed($urandom_range(0, 8000)) - 4000);
            s.ay = 16'($signed($urandom_range(0, 8000)) - 4000);
            s.az = 16'($signed($urandom_range(0, 4000)) + 14000);
            s.gz = 16'($signed($urandom_range(0, 4000)) - 2000);
        end
        s.rdy = ($urandom_range(0, 3) != 0);
        s.us = (mode < 7) ? 16'($urandom_range(15000, 25000)) : 16'($urandom);
        return s;
    endfunction

    function automatic sample_t make_sample(int ax, int ay, int az, int gz, int mx, int my,
                                            int mz, bit rdy, int us);
        sample_t s;
        s.ax = 16'(ax); s.ay = 16'(ay); s.az = 16'(az); s.gz = 16'(gz);
        s.mx = 16'(mx); s.my = 16'(my); s.mz = 16'(mz); s.rdy = rdy; s.us = 16'(us);
        return s;
    endfunction

    task automatic drain();
        while (pending_samples.size() != 0 || expected_headings.size() != 0 || s_valid)
            @(posedge aclk);
        repeat (600) @(posedge aclk);
    endtask

    task automatic write_weight(input int w);
        @(posedge aclk);
        cfg_wr_en <= 1;
        cfg_wr_data <= BW'(w);
        @(posedge aclk);
        cfg_wr_en <= 0;
        gyro_weight = w;
    endtask

    initial begin
        int weights[6] = '{64225, 0, 65536, 131071, 32768, 60000};
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        // directed
        pending_samples.push_back(make_sample(0, 0, 16384, 0, 300, 0, 0, 1, 20000));
        pending_samples.push_back(make_sample(0, 0, 0, 0, 0, 0, 0, 1, 0));
        pending_samples.push_back(make_sample(-32768, -32768, -32768, -32768, -32768,
                                              -32768, -32768, 1, 65535));
        pending_samples.push_back(make_sample(32767, 32767, 32767, 32767, 32767, 32767,
                                              32767, 1, 65535));
        pending_samples.push_back(make_sample(0, 0, 16384, 32767, 0, 0, 0, 0, 65535));
        pending_samples.push_back(make_sample(0, 0, 16384, -32768, 0, 0, 0, 0, 65535));
        pending_samples.push_back(make_sample(0, 0, 16384, 131, -300, 1, 0, 1, 20000));
        pending_samples.push_back(make_sample(0, 0, -16384, 0, -300, -1, 0, 1, 1));
        pending_samples.push_back(make_sample(16384, 0, 0, 0, 0, 300, 50, 1, 1));
        pending_samples.push_back(make_sample(-16384, 0, 0, 0, 0, -300, 0, 1, 0));
        pending_samples.push_back(make_sample(0, 16384, 0, 500, 10, 10, 10, 0, 1000));
        pending_samples.push_back(make_sample(0, 0, 16384, 1, 0, 0, 0, 0, 500));
        drain();
        sender_hold = 0;
        foreach (weights[k]) begin
            write_weight(weights[k]);
            for (int n = 0; n < 230; n++) pending_samples.push_back(rand_sample());
            if (k == 2) begin
                repeat (2000) @(posedge aclk);
                sender_hold = 1;
                while (expected_headings.size() != 0 || s_valid) @(posedge aclk);
                sender_hold = 0;
                for (int n = 0; n < 5; n++) pending_samples.push_back(rand_sample());
            end
            drain();
        end
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
